// ----- src/dru_pkg.sv -----
package dru_pkg;

    // Field widths
    localparam int DIST_W          = 18;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int TIME_W          = 32;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC      = 12;
    localparam int CASE_W          = 2;

    // Physical constants, speeds in Q.8 m/s
    localparam int MS_PER_S = 1000;
    localparam int MS_W     = $clog2(MS_PER_S + 1);
    localparam int SOUND_Q8 = 340 * 256;
    localparam int CLAMP_Q8 = 35 * 256;

    // Speed path: |d| * 1000 * scale, then drop the scale fraction
    localparam int PROD_W     = DIST_W + MS_W;
    localparam int NUM_FULL_W = PROD_W + SCALE_W;
    localparam int NUM_W      = NUM_FULL_W - SCALE_FRAC;
    localparam int SND_W      = $clog2(SOUND_Q8 + 1);
    localparam int SPD_QW     = $clog2(CLAMP_Q8 + 1);
    localparam int SUP_W      = TIME_W + SND_W;
    localparam int CLP_W      = TIME_W + SPD_QW;
    localparam int SPD_CMP_W  = NUM_W + TIME_W;

    // Ratio path: (SOUND << frac) / (SOUND +/- clamped speed)
    localparam int RATIO_W   = RATIO_FRAC_BITS + 1;
    localparam int DIVSR_W   = $clog2(SOUND_Q8 + CLAMP_Q8 + 1);
    localparam int RDIVD_W   = SND_W + RATIO_FRAC_BITS;
    localparam int RAT_CMP_W = RDIVD_W + DIVSR_W;

    localparam logic [RDIVD_W-1:0] RATIO_DIVIDEND = RDIVD_W'(SOUND_Q8) << RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0] RATIO_ONE      = RATIO_W'(1) << RATIO_FRAC_BITS;

    // Result codes
    localparam logic [CASE_W-1:0] CASE_COMPUTED   = 2'd0;
    localparam logic [CASE_W-1:0] CASE_CAMERA     = 2'd1;
    localparam logic [CASE_W-1:0] CASE_DEGENERATE = 2'd2;
    localparam logic [CASE_W-1:0] CASE_SUPERSONIC = 2'd3;

    // Sideband that rides along the divider pipelines
    typedef struct packed {
        logic              away;
        logic              clamp;
        logic [CASE_W-1:0] code;
    } dru_side_t;

endpackage

// ----- src/dru_speed_div.sv -----
// Restoring divider, one quotient bit per stage: quot = num / den.
// Only exact when the true quotient is below 2**SPD_QW.
module dru_speed_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [dru_pkg::NUM_W-1:0]    num,
    input  logic [dru_pkg::TIME_W-1:0]   den,
    input  dru_pkg::dru_side_t           in_side,
    output logic                         out_valid,
    output logic [dru_pkg::SPD_QW-1:0]   quot,
    output dru_pkg::dru_side_t           out_side
);

    localparam int NW = dru_pkg::NUM_W;
    localparam int TW = dru_pkg::TIME_W;
    localparam int QW = dru_pkg::SPD_QW;
    localparam int CW = dru_pkg::SPD_CMP_W;

    logic               valid_reg [QW];
    logic [QW-1:0]      q_reg     [QW];
    dru_pkg::dru_side_t side_reg  [QW];
    logic [NW-1:0]      rem_reg   [QW-1];
    logic [TW-1:0]      den_reg   [QW-1];

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        localparam int B = QW - 1 - i;

        logic               valid_in;
        logic [NW-1:0]      rem_in;
        logic [TW-1:0]      den_in;
        logic [QW-1:0]      q_in;
        dru_pkg::dru_side_t side_in;
        logic [CW-1:0]      trial;
        logic               take;
        logic [NW-1:0]      rem_next;
        logic [QW-1:0]      q_next;

        if (i == 0)
        begin : g_head
            assign valid_in = in_valid;
            assign rem_in   = num;
            assign den_in   = den;
            assign q_in     = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_tail
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign q_in     = q_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        assign trial = CW'(den_in) << B;
        assign take  = CW'(rem_in) >= trial;

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (take)
            begin
                rem_next = NW'(CW'(rem_in) - trial);
            end
            q_next[B] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i]    <= q_next;
                side_reg[i] <= side_in;
            end
        end

        // last stage needs no remainder or divisor
        if (i < QW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- src/dru_ratio_div.sv -----
// Restoring divider for the ratio, one quotient bit per stage:
// quot = RATIO_DIVIDEND / divisor.
module dru_ratio_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [dru_pkg::DIVSR_W-1:0]   divisor,
    input  dru_pkg::dru_side_t            in_side,
    output logic                          out_valid,
    output logic [dru_pkg::RATIO_W-1:0]   quot,
    output dru_pkg::dru_side_t            out_side
);

    localparam int RW = dru_pkg::RDIVD_W;
    localparam int DW = dru_pkg::DIVSR_W;
    localparam int QW = dru_pkg::RATIO_W;
    localparam int CW = dru_pkg::RAT_CMP_W;

    logic               valid_reg [QW];
    logic [QW-1:0]      q_reg     [QW];
    dru_pkg::dru_side_t side_reg  [QW];
    logic [RW-1:0]      rem_reg   [QW-1];
    logic [DW-1:0]      dsr_reg   [QW-1];

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        localparam int B = QW - 1 - i;

        logic               valid_in;
        logic [RW-1:0]      rem_in;
        logic [DW-1:0]      dsr_in;
        logic [QW-1:0]      q_in;
        dru_pkg::dru_side_t side_in;
        logic [CW-1:0]      trial;
        logic               take;
        logic [RW-1:0]      rem_next;
        logic [QW-1:0]      q_next;

        if (i == 0)
        begin : g_head
            assign valid_in = in_valid;
            assign rem_in   = dru_pkg::RATIO_DIVIDEND;
            assign dsr_in   = divisor;
            assign q_in     = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_tail
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign dsr_in   = dsr_reg[i-1];
            assign q_in     = q_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        assign trial = CW'(dsr_in) << B;
        assign take  = CW'(rem_in) >= trial;

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (take)
            begin
                rem_next = RW'(CW'(rem_in) - trial);
            end
            q_next[B] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i]    <= q_next;
                side_reg[i] <= side_in;
            end
        end

        if (i < QW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    dsr_reg[i] <= dsr_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- src/doppler_ratio_unit_core.sv -----
// Pipeline from an input beat to its result on the output register
//   (5 front stages, 14 speed-divider stages, 1 divisor stage, 17 ratio-divider stages, 1 out).
// Throughput: one beat per cycle; the pipeline freezes as a whole only while a result
//   waits in the output register with out_stall high, so bubbles are not squeezed out.
// Reset: rst_n (async, active low) clears every stage valid bit; payload is not reset.
// No clearing pass; the block takes a beat in the first cycle after reset.
module doppler_ratio_unit_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [dru_pkg::DIST_W-1:0]            prev_distance,
    input  logic [dru_pkg::DIST_W-1:0]            cur_distance,
    input  logic [dru_pkg::TIME_W-1:0]            prev_time_ms,
    input  logic [dru_pkg::TIME_W-1:0]            cur_time_ms,
    input  logic [dru_pkg::SCALE_W-1:0]           time_scale,
    input  logic                                  camera_switched,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dru_pkg::RATIO_W-1:0]           freq_ratio,
    output logic [dru_pkg::CASE_W-1:0]            case_code
);

    // Global advance: everything moves unless the output beat is held.
    logic en;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // Stage A: distance delta, elapsed time, special-case flags
    // ------------------------------------------------------------------
    logic                          a_valid_reg;
    logic                          a_cam_reg;
    logic                          a_degen_reg;
    logic                          a_away_reg;
    logic [dru_pkg::DIST_W-1:0]    a_dmag_reg;
    logic [dru_pkg::TIME_W-1:0]    a_dt_reg;
    logic [dru_pkg::SCALE_W-1:0]   a_scale_reg;

    logic                          a_degen_next;
    logic                          a_away_next;
    logic [dru_pkg::DIST_W-1:0]    a_dmag_next;

    always_comb
    begin
        a_degen_next = (time_scale == '0) || (cur_distance == prev_distance)
                       || (cur_time_ms <= prev_time_ms);
        a_away_next  = cur_distance > prev_distance;
        a_dmag_next  = a_away_next ? cur_distance - prev_distance
                                   : prev_distance - cur_distance;
    end

    // ------------------------------------------------------------------
    // Stage B: |d| * 1000
    // ------------------------------------------------------------------
    logic                          b_valid_reg;
    logic                          b_cam_reg;
    logic                          b_degen_reg;
    logic                          b_away_reg;
    logic [dru_pkg::PROD_W-1:0]    b_prod_reg;
    logic [dru_pkg::TIME_W-1:0]    b_dt_reg;
    logic [dru_pkg::SCALE_W-1:0]   b_scale_reg;

    // ------------------------------------------------------------------
    // Stage C: times scale, drop the Q4.12 fraction (floor is safe here:
    // floor(floor(x / 4096) / t) == floor(x / (4096 t)))
    // ------------------------------------------------------------------
    logic                              c_valid_reg;
    logic                              c_cam_reg;
    logic                              c_degen_reg;
    logic                              c_away_reg;
    logic [dru_pkg::NUM_W-1:0]         c_num_reg;
    logic [dru_pkg::TIME_W-1:0]        c_dt_reg;
    logic [dru_pkg::NUM_FULL_W-1:0]    c_full;

    assign c_full = dru_pkg::NUM_FULL_W'(b_prod_reg) * dru_pkg::NUM_FULL_W'(b_scale_reg);

    // ------------------------------------------------------------------
    // Stage D: thresholds dt * 340 m/s and dt * (35 m/s + 1 lsb)
    // ------------------------------------------------------------------
    logic                          d_valid_reg;
    logic                          d_cam_reg;
    logic                          d_degen_reg;
    logic                          d_away_reg;
    logic [dru_pkg::NUM_W-1:0]     d_num_reg;
    logic [dru_pkg::TIME_W-1:0]    d_dt_reg;
    logic [dru_pkg::SUP_W-1:0]     d_sup_lim_reg;
    logic [dru_pkg::CLP_W-1:0]     d_clp_lim_reg;

    // ------------------------------------------------------------------
    // Stage E: resolve the case code; speed >= 340 or > 35 decided here,
    // so the speed divider only ever needs SPD_QW quotient bits.
    // ------------------------------------------------------------------
    logic                          e_valid_reg;
    logic [dru_pkg::NUM_W-1:0]     e_num_reg;
    logic [dru_pkg::TIME_W-1:0]    e_dt_reg;
    dru_pkg::dru_side_t            e_side_reg;
    dru_pkg::dru_side_t            e_side_next;
    logic                          e_sup;

    always_comb
    begin
        e_sup             = dru_pkg::SUP_W'(d_num_reg) >= d_sup_lim_reg;
        e_side_next.away  = d_away_reg;
        e_side_next.clamp = dru_pkg::SUP_W'(d_num_reg) >= dru_pkg::SUP_W'(d_clp_lim_reg);
        priority if (d_cam_reg)
        begin
            e_side_next.code = dru_pkg::CASE_CAMERA;
        end
        else if (d_degen_reg)
        begin
            e_side_next.code = dru_pkg::CASE_DEGENERATE;
        end
        else if (e_sup)
        begin
            e_side_next.code = dru_pkg::CASE_SUPERSONIC;
        end
        else
        begin
            e_side_next.code = dru_pkg::CASE_COMPUTED;
        end
    end

    // Front stages, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Front stages, payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cam_reg     <= camera_switched;
            a_degen_reg   <= a_degen_next;
            a_away_reg    <= a_away_next;
            a_dmag_reg    <= a_dmag_next;
            a_dt_reg      <= cur_time_ms - prev_time_ms;
            a_scale_reg   <= time_scale;

            b_cam_reg     <= a_cam_reg;
            b_degen_reg   <= a_degen_reg;
            b_away_reg    <= a_away_reg;
            b_prod_reg    <= dru_pkg::PROD_W'(a_dmag_reg)
                             * dru_pkg::PROD_W'(dru_pkg::MS_PER_S);
            b_dt_reg      <= a_dt_reg;
            b_scale_reg   <= a_scale_reg;

            c_cam_reg     <= b_cam_reg;
            c_degen_reg   <= b_degen_reg;
            c_away_reg    <= b_away_reg;
            c_num_reg     <= c_full[dru_pkg::NUM_FULL_W-1:dru_pkg::SCALE_FRAC];
            c_dt_reg      <= b_dt_reg;

            d_cam_reg     <= c_cam_reg;
            d_degen_reg   <= c_degen_reg;
            d_away_reg    <= c_away_reg;
            d_num_reg     <= c_num_reg;
            d_dt_reg      <= c_dt_reg;
            d_sup_lim_reg <= dru_pkg::SUP_W'(c_dt_reg) * dru_pkg::SUP_W'(dru_pkg::SOUND_Q8);
            d_clp_lim_reg <= dru_pkg::CLP_W'(c_dt_reg)
                             * dru_pkg::CLP_W'(dru_pkg::CLAMP_Q8 + 1);

            e_num_reg     <= d_num_reg;
            e_dt_reg      <= d_dt_reg;
            e_side_reg    <= e_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Speed divider: |speed| = num / dt, exact whenever clamp is clear
    // ------------------------------------------------------------------
    logic                          spd_valid;
    logic [dru_pkg::SPD_QW-1:0]    spd_q;
    dru_pkg::dru_side_t            spd_side;

    dru_speed_div u_speed_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num       (e_num_reg),
        .den       (e_dt_reg),
        .in_side   (e_side_reg),
        .out_valid (spd_valid),
        .quot      (spd_q),
        .out_side  (spd_side)
    );

    // ------------------------------------------------------------------
    // Stage F: clamp to 35 m/s, form 340 +/- speed
    // ------------------------------------------------------------------
    logic                           f_valid_reg;
    logic [dru_pkg::DIVSR_W-1:0]    f_divisor_reg;
    dru_pkg::dru_side_t             f_side_reg;
    logic [dru_pkg::SPD_QW-1:0]     f_speed;
    logic [dru_pkg::DIVSR_W-1:0]    f_divisor_next;

    always_comb
    begin
        f_speed        = spd_side.clamp ? dru_pkg::SPD_QW'(dru_pkg::CLAMP_Q8) : spd_q;
        f_divisor_next = spd_side.away
                         ? dru_pkg::DIVSR_W'(dru_pkg::SOUND_Q8) + dru_pkg::DIVSR_W'(f_speed)
                         : dru_pkg::DIVSR_W'(dru_pkg::SOUND_Q8) - dru_pkg::DIVSR_W'(f_speed);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= spd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_divisor_reg <= f_divisor_next;
            f_side_reg    <= spd_side;
        end
    end

    // ------------------------------------------------------------------
    // Ratio divider: (340 << frac) / divisor, floored
    // ------------------------------------------------------------------
    logic                           rat_valid;
    logic [dru_pkg::RATIO_W-1:0]    rat_q;
    dru_pkg::dru_side_t             rat_side;

    dru_ratio_div u_ratio_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .divisor   (f_divisor_reg),
        .in_side   (f_side_reg),
        .out_valid (rat_valid),
        .quot      (rat_q),
        .out_side  (rat_side)
    );

    // ------------------------------------------------------------------
    // Output register: special cases force exactly 1.0
    // ------------------------------------------------------------------
    logic                           out_valid_reg;
    logic [dru_pkg::RATIO_W-1:0]    out_ratio_reg;
    logic [dru_pkg::CASE_W-1:0]     out_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ratio_reg <= (rat_side.code == dru_pkg::CASE_COMPUTED) ? rat_q
                                                                       : dru_pkg::RATIO_ONE;
            out_code_reg  <= rat_side.code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign freq_ratio = out_ratio_reg;
    assign case_code  = out_code_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    localparam logic [dru_pkg::RATIO_W-1:0] RATIO_MIN =
        dru_pkg::RATIO_W'(dru_pkg::RATIO_DIVIDEND / (dru_pkg::SOUND_Q8 + dru_pkg::CLAMP_Q8));
    localparam logic [dru_pkg::RATIO_W-1:0] RATIO_MAX =
        dru_pkg::RATIO_W'(dru_pkg::RATIO_DIVIDEND / (dru_pkg::SOUND_Q8 - dru_pkg::CLAMP_Q8));

    // Unclamped computed speeds come out of the divider at or below the clamp.
    a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        spd_valid && !spd_side.clamp && spd_side.code == dru_pkg::CASE_COMPUTED
        |-> spd_q <= dru_pkg::SPD_QW'(dru_pkg::CLAMP_Q8))
        else $error("speed quotient above clamp without clamp flag");

    a_divisor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && f_side_reg.code == dru_pkg::CASE_COMPUTED
        |-> f_divisor_reg >= dru_pkg::DIVSR_W'(dru_pkg::SOUND_Q8 - dru_pkg::CLAMP_Q8)
            && f_divisor_reg <= dru_pkg::DIVSR_W'(dru_pkg::SOUND_Q8 + dru_pkg::CLAMP_Q8))
        else $error("ratio divisor outside 305..375 m/s");

    a_special_is_unity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && case_code != dru_pkg::CASE_COMPUTED |-> freq_ratio == dru_pkg::RATIO_ONE)
        else $error("special case did not give ratio 1.0");

    a_ratio_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && case_code == dru_pkg::CASE_COMPUTED
        |-> freq_ratio >= RATIO_MIN && freq_ratio <= RATIO_MAX)
        else $error("computed ratio outside clamp bounds");

endmodule
